@@ rtl/core/csl_pkg.sv @@
// Package: token codes, scanner modes, character classes and keyword lookup
package csl_pkg;

	localparam int LINE_BITS_DEF   = 24;
	localparam int IDENT_CHARS_DEF = 8;
	localparam int KIND_W          = 6;
	localparam int CONST_W         = 32;
	localparam int TEXT_W          = 64;
	localparam int LEN_W           = 4;
	localparam int QUEUE_DEPTH     = 4;

	// Token codes in name-table order
	typedef enum logic [KIND_W-1:0] {
		T_EOF, T_IDENT, T_CONST, T_AUTO, T_DO, T_ELSE, T_EXTERN, T_FOR, T_IF, T_INLINE,
		T_REGISTER, T_STATIC, T_TYPEDEF, T_WHILE, T_INT, T_LPAREN, T_RPAREN, T_LBRACE,
		T_RBRACE, T_AMP, T_STAR, T_PLUS, T_MINUS, T_SLASH, T_PERCENT, T_LT, T_GT, T_SHL,
		T_SHR, T_LE, T_GE, T_EQEQ, T_OR, T_XOR, T_ANDAND, T_OROR, T_QUEST, T_ASSIGN,
		T_MULEQ, T_DIVEQ, T_MODEQ, T_ADDEQ, T_SUBEQ, T_SHLEQ, T_SHREQ, T_ANDEQ, T_XOREQ,
		T_OREQ, T_COLON, T_COMMA, T_SEMI, T_LEADZERO
	} tok_kind_t;

	localparam logic [KIND_W-1:0] K_EOF   = T_EOF;
	localparam logic [KIND_W-1:0] K_IDENT = T_IDENT;
	localparam logic [KIND_W-1:0] K_CONST = T_CONST;
	localparam logic [KIND_W-1:0] K_ANDAND = T_ANDAND;
	localparam logic [KIND_W-1:0] K_OROR  = T_OROR;
	localparam logic [KIND_W-1:0] K_ERROR = T_LEADZERO;
	localparam logic [KIND_W-1:0] K_NONE  = 6'd63;

	typedef enum logic [4:0] {
		M_IDLE, M_STAR, M_PLUS, M_MINUS, M_SLASH, M_PERCENT, M_ASSIGN, M_CARET,
		M_PIPE, M_AMP, M_LESS, M_LSHIFT, M_GREATER, M_RSHIFT, M_IDENT, M_ZERO,
		M_NUM
	} mode_t;

	// One classified byte handed from the front to the back
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} byte_word_t;

	// One result word on the output queue
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [31:0]        line;
		logic [CONST_W-1:0] value;
		logic [TEXT_W-1:0]  text;
		logic [LEN_W-1:0]   len;
		logic               trunc;
		logic               last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_word(input logic [7:0] b);
		return is_digit(b) || (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A)
			|| b == 8'h5F;
	endfunction

	function automatic logic [KIND_W-1:0] plain_kind(input mode_t m);
		case (m)
			M_STAR:    return T_STAR;
			M_PLUS:    return T_PLUS;
			M_MINUS:   return T_MINUS;
			M_SLASH:   return T_SLASH;
			M_PERCENT: return T_PERCENT;
			M_ASSIGN:  return T_ASSIGN;
			M_CARET:   return T_XOR;
			M_PIPE:    return T_OR;
			M_AMP:     return T_AMP;
			M_LESS:    return T_LT;
			M_LSHIFT:  return T_SHL;
			M_GREATER: return T_GT;
			M_RSHIFT:  return T_SHR;
			default:   return K_EOF;
		endcase
	endfunction

	function automatic logic [KIND_W-1:0] eq_kind(input mode_t m);
		case (m)
			M_STAR:    return T_MULEQ;
			M_PLUS:    return T_ADDEQ;
			M_MINUS:   return T_SUBEQ;
			M_SLASH:   return T_DIVEQ;
			M_PERCENT: return T_MODEQ;
			M_ASSIGN:  return T_EQEQ;
			M_CARET:   return T_XOREQ;
			M_PIPE:    return T_OREQ;
			M_AMP:     return T_ANDEQ;
			M_LESS:    return T_LE;
			M_LSHIFT:  return T_SHLEQ;
			M_GREATER: return T_GE;
			M_RSHIFT:  return T_SHREQ;
			default:   return K_EOF;
		endcase
	endfunction

	// Keyword compare on the full zero-padded buffer; K_IDENT when no match
	function automatic logic [KIND_W-1:0] keyword_kind(input logic [TEXT_W-1:0] t);
		case (t)
			64'h6669:             return T_IF;
			64'h65736c65:         return T_ELSE;
			64'h746e69:           return T_INT;
			64'h656c696877:       return T_WHILE;
			64'h726f66:           return T_FOR;
			64'h6f64:             return T_DO;
			64'h66656465707974:   return T_TYPEDEF;
			64'h6e7265747865:     return T_EXTERN;
			64'h636974617473:     return T_STATIC;
			64'h6f747561:         return T_AUTO;
			64'h7265747369676572: return T_REGISTER;
			64'h656e696c6e69:     return T_INLINE;
			default:              return K_IDENT;
		endcase
	endfunction

	// Single-character tokens with nothing pending
	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] b);
		case (b)
			8'h28:   return T_LPAREN;
			8'h29:   return T_RPAREN;
			8'h7B:   return T_LBRACE;
			8'h7D:   return T_RBRACE;
			8'h3F:   return T_QUEST;
			8'h3A:   return T_COLON;
			8'h2C:   return T_COMMA;
			8'h3B:   return T_SEMI;
			default: return K_NONE;
		endcase
	endfunction

	function automatic mode_t start_mode(input logic [7:0] b);
		case (b)
			8'h2A:   return M_STAR;
			8'h2B:   return M_PLUS;
			8'h2D:   return M_MINUS;
			8'h2F:   return M_SLASH;
			8'h25:   return M_PERCENT;
			8'h3D:   return M_ASSIGN;
			8'h5E:   return M_CARET;
			8'h7C:   return M_PIPE;
			8'h26:   return M_AMP;
			8'h3C:   return M_LESS;
			8'h3E:   return M_GREATER;
			8'h30:   return M_ZERO;
			default: return is_digit(b) ? M_NUM : (is_word(b) ? M_IDENT : M_IDLE);
		endcase
	endfunction

endpackage

@@ rtl/core/csl_fifo.sv @@
// Small register queue, instantiated once for the byte path and once for the token path
module csl_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign full  = cnt_q == (AW+1)'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd && !empty) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
		end
	end
endmodule

@@ rtl/core/csl_scan.sv @@
// Back end: lexer FSM, up to three tokens per byte; one byte per cycle if it makes at most one and output has room
module csl_scan #(
	parameter int LINE_BITS = csl_pkg::LINE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  csl_pkg::byte_word_t in_word,
	output logic                in_take,
	output logic                out_wr,
	output csl_pkg::token_t     out_tok,
	input  logic                out_full
);
	csl_pkg::mode_t mode_q, mode_n;
	logic [csl_pkg::TEXT_W-1:0] buf_q, buf_n;
	logic [csl_pkg::LEN_W-1:0]  cnt_q, cnt_n;
	logic                       ovf_q, ovf_n;
	logic [31:0]                num_q, num_n;
	logic [LINE_BITS-1:0]       line_q, line_n;
	logic                       halt_q, halt_n;

	// tokens of the current byte, issued one per cycle while the token queue is not full
	csl_pkg::token_t tok [3];
	logic [1:0] ntok;
	logic [1:0] idx_q;
	logic       done;

	logic [7:0] b;
	logic       used;
	csl_pkg::token_t blank, t;
	csl_pkg::mode_t  sm;
	logic [csl_pkg::KIND_W-1:0] sk;

	assign b = in_word.ch;

	always_comb begin
		mode_n = mode_q; buf_n = buf_q; cnt_n = cnt_q; ovf_n = ovf_q;
		num_n = num_q; line_n = line_q; halt_n = halt_q;
		used = 1'b0; ntok = '0;
		blank = '0;
		blank.line = 32'(line_q);
		tok[0] = blank; tok[1] = blank; tok[2] = blank;
		t = blank;
		sm = csl_pkg::start_mode(b);
		sk = csl_pkg::single_kind(b);
		if (!halt_q) begin
			// pending-token handling with lookahead
			t = blank;
			case (mode_q)
				csl_pkg::M_IDLE: ;
				csl_pkg::M_IDENT: begin
					if (csl_pkg::is_word(b)) begin
						used = 1'b1;
						if (cnt_q < csl_pkg::LEN_W'(csl_pkg::IDENT_CHARS_DEF)) begin
							buf_n = buf_q | (csl_pkg::TEXT_W'(b) << {cnt_q[2:0], 3'b000});
							cnt_n = cnt_q + 1'b1;
						end else ovf_n = 1'b1;
					end else begin
						t.kind = ovf_q ? csl_pkg::K_IDENT : csl_pkg::keyword_kind(buf_q);
						if (t.kind == csl_pkg::K_IDENT) begin
							t.text = buf_q; t.len = cnt_q; t.trunc = ovf_q;
						end
						tok[0] = t; ntok = 2'd1;
					end
				end
				csl_pkg::M_ZERO, csl_pkg::M_NUM: begin
					if (mode_q == csl_pkg::M_ZERO && csl_pkg::is_digit(b)) begin
						t.kind = csl_pkg::K_ERROR; t.last = 1'b1;
						tok[0] = t; ntok = 2'd1;
						halt_n = 1'b1; used = 1'b1;
					end else if (mode_q == csl_pkg::M_NUM && csl_pkg::is_digit(b)) begin
						num_n = (num_q << 3) + (num_q << 1) + 32'(b - 8'h30);
						used = 1'b1;
					end else begin
						t.kind = csl_pkg::K_CONST; t.value = num_q;
						tok[0] = t; ntok = 2'd1;
					end
				end
				default: begin
					used = 1'b1;
					if (b == 8'h3D) t.kind = csl_pkg::eq_kind(mode_q);
					else if (mode_q == csl_pkg::M_PIPE && b == 8'h7C) t.kind = csl_pkg::K_OROR;
					else if (mode_q == csl_pkg::M_AMP && b == 8'h26) t.kind = csl_pkg::K_ANDAND;
					else if ((mode_q == csl_pkg::M_LESS && b == 8'h3C) ||
						(mode_q == csl_pkg::M_GREATER && b == 8'h3E)) begin
						t.kind = csl_pkg::K_NONE;
						mode_n = (mode_q == csl_pkg::M_LESS) ? csl_pkg::M_LSHIFT
							: csl_pkg::M_RSHIFT;
					end else begin
						t.kind = csl_pkg::plain_kind(mode_q);
						used = 1'b0;
					end
					if (t.kind != csl_pkg::K_NONE) begin
						tok[0] = t; ntok = 2'd1;
					end
				end
			endcase
			if (!halt_n) begin
				if (!used) begin
					buf_n = '0; cnt_n = '0; ovf_n = 1'b0; num_n = '0;
					mode_n = csl_pkg::M_IDLE;
				end else if (mode_n == mode_q && ntok != 2'd0) begin
					mode_n = csl_pkg::M_IDLE;
				end
				// fresh byte with nothing pending
				if (!used) begin
					if (b == 8'h0A) begin
						if (line_q != '1) line_n = line_q + 1'b1;
					end else if (sk != csl_pkg::K_NONE) begin
						t = blank; t.kind = sk;
						tok[ntok] = t; ntok = ntok + 1'b1;
					end else begin
						mode_n = sm;
						if (sm == csl_pkg::M_NUM) num_n = 32'(b - 8'h30);
						if (sm == csl_pkg::M_IDENT) begin
							buf_n = csl_pkg::TEXT_W'(b); cnt_n = csl_pkg::LEN_W'(1);
						end
					end
				end
				// end of text: flush then end-of-file, on the line after this byte
				if (in_word.last) begin
					t = blank; t.line = 32'(line_n);
					case (mode_n)
						csl_pkg::M_IDLE: t.kind = csl_pkg::K_NONE;
						csl_pkg::M_IDENT: begin
							t.kind = ovf_n ? csl_pkg::K_IDENT : csl_pkg::keyword_kind(buf_n);
							if (t.kind == csl_pkg::K_IDENT) begin
								t.text = buf_n; t.len = cnt_n; t.trunc = ovf_n;
							end
						end
						csl_pkg::M_ZERO, csl_pkg::M_NUM: begin
							t.kind = csl_pkg::K_CONST; t.value = num_n;
						end
						default: t.kind = csl_pkg::plain_kind(mode_n);
					endcase
					if (t.kind != csl_pkg::K_NONE) begin
						tok[ntok] = t; ntok = ntok + 1'b1;
					end
					t = blank; t.line = 32'(line_n); t.kind = csl_pkg::K_EOF;
					tok[ntok] = t; ntok = ntok + 1'b1;
					mode_n = csl_pkg::M_IDLE; buf_n = '0; cnt_n = '0; ovf_n = 1'b0;
					num_n = '0; line_n = '0;
				end
			end else mode_n = csl_pkg::M_IDLE;
		end
		out_tok = tok[idx_q];
		out_tok.last = (idx_q == ntok - 1'b1);
	end

	assign out_wr  = in_valid && ntok != '0 && !out_full;
	assign done    = ntok == '0 || (out_wr && idx_q == ntok - 1'b1);
	assign in_take = in_valid && done;

	// state update once the byte's tokens are all queued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csl_pkg::M_IDLE; buf_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
			num_q <= '0; line_q <= '0; halt_q <= 1'b0; idx_q <= '0;
		end else if (in_take) begin
			mode_q <= mode_n; buf_q <= buf_n; cnt_q <= cnt_n; ovf_q <= ovf_n;
			num_q <= num_n; line_q <= line_n; halt_q <= halt_n; idx_q <= '0;
		end else if (out_wr) begin
			idx_q <= idx_q + 1'b1;
		end
	end
endmodule

@@ rtl/core/c_subset_lexer.sv @@
// Top level: byte queue front, scanner back, token queue out
//
// channel | dir | handshake     | words
// input   | in  | push / full   | byte_in, end_of_text
// result  | out | pop / empty   | token_kind .. last_of_run
//
// A byte that makes zero or one token is taken once that token, if any, is
// written; a byte that makes two or three tokens holds the scanner until all
// are written to the output queue. Queues of four words sit on both sides, so
// either side may stall independently. arst_n clears all state; after a
// leading-zero error the block drops bytes and sends nothing until reset.
module c_subset_lexer #(
	parameter int LINE_BITS = csl_pkg::LINE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [7:0]                  byte_in,
	input  logic                        end_of_text,
	output logic                        empty,
	input  logic                        pop,
	output logic [csl_pkg::KIND_W-1:0]  token_kind,
	output logic [LINE_BITS-1:0]        line_number,
	output logic [csl_pkg::CONST_W-1:0] constant_value,
	output logic [csl_pkg::TEXT_W-1:0]  ident_text,
	output logic [csl_pkg::LEN_W-1:0]   ident_length,
	output logic                        ident_truncated,
	output logic                        last_of_run
);
	csl_pkg::byte_word_t bw_in, bw_out;
	csl_pkg::token_t     tk_in, tk_out;
	logic b_empty, take, t_wr, t_full;

	assign bw_in.ch   = byte_in;
	assign bw_in.last = end_of_text;

	// front: incoming byte queue
	csl_fifo #(.W($bits(csl_pkg::byte_word_t)), .DEPTH(csl_pkg::QUEUE_DEPTH)) u_bq (
		.clk, .arst_n, .wr(push), .wdata(bw_in), .full,
		.rd(take), .rdata(bw_out), .empty(b_empty)
	);

	csl_scan #(.LINE_BITS(LINE_BITS)) u_scan (
		.clk, .arst_n, .in_valid(!b_empty), .in_word(bw_out), .in_take(take),
		.out_wr(t_wr), .out_tok(tk_in), .out_full(t_full)
	);

	// back: token queue
	csl_fifo #(.W($bits(csl_pkg::token_t)), .DEPTH(csl_pkg::QUEUE_DEPTH)) u_tq (
		.clk, .arst_n, .wr(t_wr), .wdata(tk_in), .full(t_full),
		.rd(pop), .rdata(tk_out), .empty
	);

	assign token_kind      = tk_out.kind;
	assign line_number     = tk_out.line[LINE_BITS-1:0];
	assign constant_value  = tk_out.value;
	assign ident_text      = tk_out.text;
	assign ident_length    = tk_out.len;
	assign ident_truncated = tk_out.trunc;
	assign last_of_run     = tk_out.last;

`ifndef SYNTHESIS
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ident_length <= 4'd8) else $error("ident length over eight");
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && token_kind == csl_pkg::K_EOF) |-> last_of_run)
		else $error("end-of-file not last of run");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		t_wr |-> !t_full) else $error("token write into full queue");
`endif
endmodule
